// ----- hdl/gpsd_pkg.sv -----
// package for the gray code / phase shift pixel decoder
// types, constants and the cordic angle table; no dependencies
`timescale 1ns / 1ps
package gpsd_pkg;

  localparam int GRAY_PATTERNS_DEF   = 8;
  localparam int PHASE_FRAC_BITS_DEF = 16;
  localparam int CORDIC_STEPS        = 28;
  localparam int CORDIC_SCALE_BITS   = 24;
  localparam int CW                  = 36;
  localparam int COORD_W             = 23;
  localparam logic [7:0] FRINGE_PERIOD_RESET = 8'd16;

  typedef struct packed {
    logic [7:0]  black_level;
    logic [7:0]  white_level;
    logic [63:0] gray_samples;
    logic [7:0]  phase_sample_0;
    logic [7:0]  phase_sample_1;
    logic [7:0]  phase_sample_2;
    logic [7:0]  phase_sample_3;
  } pixel_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] projector_coordinate;
    logic               in_mask;
    logic [7:0]         gray_code_value;
  } pixel_out_t;

  typedef struct packed {
    logic        mask;
    logic [7:0]  code;
  } side_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [31:0]          z;
    logic                 zero;
  } cordic_t;

  function automatic logic [31:0] atan_turns(input int i);
    logic [31:0] t;
    case (i)
      0: t = 32'd536870912;  1: t = 32'd316933406;  2: t = 32'd167458907;
      3: t = 32'd85004756;   4: t = 32'd42667331;   5: t = 32'd21354465;
      6: t = 32'd10679838;   7: t = 32'd5340245;    8: t = 32'd2670163;
      9: t = 32'd1335087;    10: t = 32'd667544;    11: t = 32'd333772;
      12: t = 32'd166886;    13: t = 32'd83443;     14: t = 32'd41722;
      15: t = 32'd20861;     16: t = 32'd10430;     17: t = 32'd5215;
      18: t = 32'd2608;      19: t = 32'd1304;      20: t = 32'd652;
      21: t = 32'd326;       22: t = 32'd163;       23: t = 32'd81;
      24: t = 32'd41;        25: t = 32'd20;        26: t = 32'd10;
      27: t = 32'd5;
      default: t = 32'd0;
    endcase
    return t;
  endfunction

endpackage

// ----- hdl/gray_phase_shift_pixel_decode.sv -----
// Structured-light pixel decoder. One pixel is taken per clock (busy is never high) and its
// result is on the ports with result_valid once it has passed 18 register stages: one front
// stage, 14 cordic stages of two micro-rotations each, and three back stages for unwrap, period
// multiply and saturation. Results cannot be held off. fringe_period is to be written by the
// user through cfg_valid/cfg_ready only while idle; the block itself does not enforce this.
// depends on gpsd_pkg, gpsd_front, gpsd_cordic, gpsd_back
`timescale 1ns / 1ps
module gray_phase_shift_pixel_decode #(
  parameter int GRAY_PATTERNS   = gpsd_pkg::GRAY_PATTERNS_DEF,
  parameter int PHASE_FRAC_BITS = gpsd_pkg::PHASE_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  gpsd_pkg::pixel_in_t  pixel,
  output logic                 result_valid,
  output gpsd_pkg::pixel_out_t result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_data
);
  logic [7:0] fringe_period;
  logic              f_valid;
  gpsd_pkg::side_t   f_side;
  gpsd_pkg::cordic_t f_cor;
  logic              c_valid;
  gpsd_pkg::side_t   c_side;
  gpsd_pkg::cordic_t c_cor;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fringe_period <= gpsd_pkg::FRINGE_PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      fringe_period <= cfg_data;
    end
  end

  gpsd_front #(.GRAY_PATTERNS(GRAY_PATTERNS)) u_front (
    .clk(clk), .rst(rst), .in_valid(start && !busy), .in_pix(pixel),
    .out_valid(f_valid), .out_side(f_side), .out_cor(f_cor)
  );

  gpsd_cordic u_cordic (
    .clk(clk), .rst(rst), .in_valid(f_valid), .in_side(f_side), .in_cor(f_cor),
    .out_valid(c_valid), .out_side(c_side), .out_cor(c_cor)
  );

  gpsd_back #(.PHASE_FRAC_BITS(PHASE_FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .fringe_period(fringe_period), .in_valid(c_valid),
    .in_side(c_side), .in_cor(c_cor), .out_valid(result_valid), .out_pix(result)
  );
endmodule

// ----- hdl/gpsd_front.sv -----
// front stage: threshold, mask, gray decode and cordic pre-rotation
// depends on gpsd_pkg
`timescale 1ns / 1ps
module gpsd_front #(
  parameter int GRAY_PATTERNS = gpsd_pkg::GRAY_PATTERNS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  gpsd_pkg::pixel_in_t in_pix,
  output logic                out_valid,
  output gpsd_pkg::side_t     out_side,
  output gpsd_pkg::cordic_t   out_cor
);
  localparam int CW = gpsd_pkg::CW;

  logic [8:0] sum;
  logic [7:0] thr;
  logic [7:0] diff;
  logic       mask;
  logic [7:0] code;
  logic [GRAY_PATTERNS-1:0] bits;
  logic signed [8:0] xi;
  logic signed [8:0] yi;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  gpsd_pkg::side_t   side_next;
  gpsd_pkg::cordic_t cor_next;

  always_comb begin
    sum  = {1'b0, in_pix.black_level} + {1'b0, in_pix.white_level} + 9'd1;
    thr  = sum[8:1];
    diff = (in_pix.white_level > in_pix.black_level) ?
           in_pix.white_level - in_pix.black_level : 8'd0;
    mask = diff > thr;
    for (int i = 0; i < GRAY_PATTERNS; i++) begin
      bits[GRAY_PATTERNS-1-i] = in_pix.gray_samples[63-8*i -: 8] > thr;
    end
    code = '0;
    for (int i = GRAY_PATTERNS - 1; i >= 0; i--) begin
      if (i == GRAY_PATTERNS - 1) begin
        code[i] = bits[i];
      end else begin
        code[i] = bits[i] ^ code[i+1];
      end
    end
    side_next.mask = mask;
    side_next.code = mask ? code : 8'd0;

    xi = $signed({1'b0, in_pix.phase_sample_0}) - $signed({1'b0, in_pix.phase_sample_2});
    yi = $signed({1'b0, in_pix.phase_sample_3}) - $signed({1'b0, in_pix.phase_sample_1});
    xs = CW'(xi) <<< gpsd_pkg::CORDIC_SCALE_BITS;
    ys = CW'(yi) <<< gpsd_pkg::CORDIC_SCALE_BITS;
    cor_next.zero = !mask || (xi == 9'sd0 && yi == 9'sd0);
    if (xi < 0) begin
      cor_next.x = -xs;
      cor_next.y = -ys;
      cor_next.z = 32'h8000_0000;
    end else begin
      cor_next.x = xs;
      cor_next.y = ys;
      cor_next.z = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_side <= side_next;
    out_cor  <= cor_next;
  end
endmodule

// ----- hdl/gpsd_cordic.sv -----
// pipelined vectoring cordic, two micro-rotations per register stage
// depends on gpsd_pkg
`timescale 1ns / 1ps
module gpsd_cordic (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  gpsd_pkg::side_t   in_side,
  input  gpsd_pkg::cordic_t in_cor,
  output logic              out_valid,
  output gpsd_pkg::side_t   out_side,
  output gpsd_pkg::cordic_t out_cor
);
  localparam int NS = gpsd_pkg::CORDIC_STEPS / 2;

  logic              vld  [NS+1];
  gpsd_pkg::side_t   side [NS+1];
  gpsd_pkg::cordic_t cor  [NS+1];

  assign vld[0]  = in_valid;
  assign side[0] = in_side;
  assign cor[0]  = in_cor;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    gpsd_pkg::cordic_t mid;
    gpsd_pkg::cordic_t fin;
    always_comb begin
      mid = cor[s];
      if (!cor[s].y[gpsd_pkg::CW-1]) begin
        mid.x = cor[s].x + (cor[s].y >>> (2*s));
        mid.y = cor[s].y - (cor[s].x >>> (2*s));
        mid.z = cor[s].z + gpsd_pkg::atan_turns(2*s);
      end else begin
        mid.x = cor[s].x - (cor[s].y >>> (2*s));
        mid.y = cor[s].y + (cor[s].x >>> (2*s));
        mid.z = cor[s].z - gpsd_pkg::atan_turns(2*s);
      end
      fin = mid;
      if (!mid.y[gpsd_pkg::CW-1]) begin
        fin.x = mid.x + (mid.y >>> (2*s+1));
        fin.y = mid.y - (mid.x >>> (2*s+1));
        fin.z = mid.z + gpsd_pkg::atan_turns(2*s+1);
      end else begin
        fin.x = mid.x - (mid.y >>> (2*s+1));
        fin.y = mid.y + (mid.x >>> (2*s+1));
        fin.z = mid.z - gpsd_pkg::atan_turns(2*s+1);
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      side[s+1] <= side[s];
      cor[s+1]  <= fin;
    end
  end

  assign out_valid = vld[NS];
  assign out_side  = side[NS];
  assign out_cor   = cor[NS];
endmodule

// ----- hdl/gpsd_back.sv -----
// back stages: phase rounding, unwrap, period scaling and saturation
// depends on gpsd_pkg
`timescale 1ns / 1ps
module gpsd_back #(
  parameter int PHASE_FRAC_BITS = gpsd_pkg::PHASE_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           fringe_period,
  input  logic                 in_valid,
  input  gpsd_pkg::side_t      in_side,
  input  gpsd_pkg::cordic_t    in_cor,
  output logic                 out_valid,
  output gpsd_pkg::pixel_out_t out_pix
);
  localparam int PF = PHASE_FRAC_BITS;
  localparam int AW = PF + 9;
  localparam int PW = AW + 8;
  localparam logic [PF-1:0] QUARTER  = PF'(1) << (PF - 2);
  localparam logic [PF-1:0] THREEQ   = PF'(3) << (PF - 2);
  localparam logic [PW-1:0] HALF_LSB = PW'(1) << (PF - 9);
  localparam logic [PW-1:0] CMAX     = PW'(23'h7F_FFFF);

  logic [31:0]   zr;
  logic [PF-1:0] p;
  logic [7:0]    k1;
  logic [7:0]    k2;
  logic signed [AW:0] absph;
  logic              v1;
  gpsd_pkg::side_t   s1;
  logic [AW-1:0]     a1;
  logic [PW-1:0]     prod;
  logic [PW-1:0]     rnd;
  logic [PW-1:0]     sh;
  logic              v2;
  gpsd_pkg::side_t   s2;
  logic [PW-1:0]     prod2;

  always_comb begin
    zr = in_cor.z + (32'd1 << (31 - PF));
    p  = in_cor.zero ? '0 : zr[31 -: PF];
    k1 = {1'b0, in_side.code[7:1]};
    k2 = 8'((9'(in_side.code) + 9'd1) >> 1);
    if (p <= QUARTER) begin
      absph = $signed({1'b0, k2, p});
    end else if (p >= THREEQ) begin
      absph = $signed({1'b0, k2, p}) - $signed((AW+1)'(1) << PF);
    end else begin
      absph = $signed({1'b0, k1, p});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
    s1 <= in_side;
    a1 <= (absph <= 0) ? '0 : absph[AW-1:0];
    s2 <= s1;
    prod2 <= PW'(a1) * PW'(fringe_period);
    out_pix.in_mask <= s2.mask;
    out_pix.gray_code_value <= s2.code;
    out_pix.projector_coordinate <= (sh > CMAX) ? CMAX[22:0] : sh[22:0];
  end

  always_comb begin
    prod = prod2;
    rnd  = prod + HALF_LSB;
    sh   = rnd >> (PF - 8);
  end
endmodule

// ----- sim/gray_phase_shift_pixel_decode_test.sv -----
// testbench for gray_phase_shift_pixel_decode: a directed table then random pixels, each result
// checked against its table value or else an in-bench fixed-point decoder model
// depends on gpsd_pkg and the rtl of gray_phase_shift_pixel_decode
`timescale 1ns / 1ps
module gray_phase_shift_pixel_decode_test;

  localparam int LATENCY    = 18;
  localparam int N_RANDOM   = 1800;
  localparam int MAX_CYCLES = 400000;

  typedef struct packed {
    logic                 has_exp;
    gpsd_pkg::pixel_in_t  pix;
    gpsd_pkg::pixel_out_t exp_out;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  gpsd_pkg::pixel_in_t  pixel = '0;
  logic                 result_valid;
  gpsd_pkg::pixel_out_t result;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [7:0]           cfg_data = '0;

  logic [7:0] period_shadow;
  gpsd_pkg::pixel_out_t expected_pixels[$];
  int         mismatches = 0;
  int         cycles = 0;
  int         idle_pct = 0;

  gray_phase_shift_pixel_decode u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("gray_phase_shift_pixel_decode_test NOT OK");
      $finish;
    end
  end

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic [15:0] phase_turns(int xi, int yi);
    longint x, y, nx, ny;
    logic [31:0] z;
    logic [31:0] t;
    z = 32'd0;
    if (xi == 0 && yi == 0) return 16'd0;
    if (xi < 0) begin
      xi = -xi;
      yi = -yi;
      z = 32'h8000_0000;
    end
    x = longint'(xi) <<< gpsd_pkg::CORDIC_SCALE_BITS;
    y = longint'(yi) <<< gpsd_pkg::CORDIC_SCALE_BITS;
    for (int i = 0; i < gpsd_pkg::CORDIC_STEPS; i++) begin
      case (i)
        0: t = 32'd536870912;  1: t = 32'd316933406;  2: t = 32'd167458907;
        3: t = 32'd85004756;   4: t = 32'd42667331;   5: t = 32'd21354465;
        6: t = 32'd10679838;   7: t = 32'd5340245;    8: t = 32'd2670163;
        9: t = 32'd1335087;    10: t = 32'd667544;    11: t = 32'd333772;
        12: t = 32'd166886;    13: t = 32'd83443;     14: t = 32'd41722;
        15: t = 32'd20861;     16: t = 32'd10430;     17: t = 32'd5215;
        18: t = 32'd2608;      19: t = 32'd1304;      20: t = 32'd652;
        21: t = 32'd326;       22: t = 32'd163;       23: t = 32'd81;
        24: t = 32'd41;        25: t = 32'd20;        26: t = 32'd10;
        default: t = 32'd5;
      endcase
      if (y >= 0) begin
        nx = x + floor_sh(y, i);
        ny = y - floor_sh(x, i);
        z = z + t;
      end else begin
        nx = x - floor_sh(y, i);
        ny = y + floor_sh(x, i);
        z = z - t;
      end
      x = nx;
      y = ny;
    end
    z = z + 32'h0000_8000;
    return z[31:16];
  endfunction

  function automatic gpsd_pkg::pixel_out_t decode_pixel(gpsd_pkg::pixel_in_t p,
                                                        logic [7:0] period);
    gpsd_pkg::pixel_out_t o;
    int thr, diff, k;
    logic acc, mask;
    logic [7:0] code, s;
    logic [15:0] ph;
    longint absph, v;
    thr = (int'(p.black_level) + int'(p.white_level) + 1) >> 1;
    diff = (p.white_level > p.black_level) ? int'(p.white_level) - int'(p.black_level) : 0;
    mask = diff > thr;
    acc = 1'b0;
    for (int i = 0; i < 8; i++) begin
      s = p.gray_samples[63 - 8*i -: 8];
      acc = acc ^ (int'(s) > thr);
      code[7 - i] = acc;
    end
    if (!mask) code = 8'd0;
    ph = mask ? phase_turns(int'(p.phase_sample_0) - int'(p.phase_sample_2),
                            int'(p.phase_sample_3) - int'(p.phase_sample_1)) : 16'd0;
    if (ph <= 16'h4000) k = (int'(code) + 1) >> 1;
    else if (ph >= 16'hC000) k = ((int'(code) + 1) >> 1) - 1;
    else k = int'(code) >> 1;
    absph = longint'(ph) + longint'(k) * 65536;
    if (absph <= 0) v = 0;
    else begin
      v = (absph * longint'(period) + 128) >>> 8;
      if (v > 8388607) v = 8388607;
    end
    o.projector_coordinate = v[22:0];
    o.in_mask = mask;
    o.gray_code_value = code;
    return o;
  endfunction

  always @(posedge clk) begin
    gpsd_pkg::pixel_out_t e;
    if (!rst && result_valid) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", result);
      end else begin
        e = expected_pixels.pop_front();
        if (result.projector_coordinate !== e.projector_coordinate ||
            result.in_mask !== e.in_mask || result.gray_code_value !== e.gray_code_value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp coord %0d mask %0b code %0d, got coord %0d mask %0b code %0d",
                     e.projector_coordinate, e.in_mask, e.gray_code_value,
                     result.projector_coordinate, result.in_mask, result.gray_code_value);
        end
      end
    end
  end

  task automatic send_pixel(gpsd_pkg::pixel_in_t p, logic has_exp, gpsd_pkg::pixel_out_t eo);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    pixel <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_pixels.insert(expected_pixels.size(), has_exp ? eo : decode_pixel(p, period_shadow));
  endtask

  task automatic drain_pipe();
    start <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_period(logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    period_shadow = val;
  endtask

  function automatic gpsd_pkg::pixel_in_t rand_pixel();
    gpsd_pkg::pixel_in_t p;
    logic [7:0] b, w, thr;
    p = {$urandom, $urandom, $urandom, 16'($urandom)};
    if ($urandom_range(9) < 8) begin
      b = 8'($urandom_range(60));
      w = 8'($urandom_range(255, 130));
      p.black_level = b;
      p.white_level = w;
      thr = 8'((int'(b) + int'(w) + 1) >> 1);
      for (int i = 0; i < 8; i++)
        p.gray_samples[63 - 8*i -: 8] = $urandom_range(1) ? 8'(thr + $urandom_range(1, 255 - thr))
                                                          : 8'($urandom_range(thr));
    end
    return p;
  endfunction

  dir_row_t dir_rows[$];

  initial begin
    gpsd_pkg::pixel_in_t p;
    logic [7:0] periods[6];
    int phase_idle[4];
    periods = '{8'd16, 8'd1, 8'd255, 8'd0, 8'd37, 8'd128};
    phase_idle = '{0, 50, 50, 33};
    // outside mask, black equals white, all extremes
    dir_rows.insert(dir_rows.size(), '{1'b1, {8'd0, 8'd0, 64'd0, 32'd0}, '{23'd0, 1'b0, 8'd0}});
    dir_rows.insert(dir_rows.size(), '{1'b1, {8'd255, 8'd255, {64{1'b1}}, {32{1'b1}}},
                                       '{23'd0, 1'b0, 8'd0}});
    dir_rows.insert(dir_rows.size(), '{1'b1, {8'd255, 8'd0, {64{1'b1}}, 32'h12345678},
                                       '{23'd0, 1'b0, 8'd0}});
    // masked, zero vector, all gray dark: code 0, phase 0
    dir_rows.insert(dir_rows.size(), '{1'b1, {8'd0, 8'd255, 64'd0, 32'h80808080},
                                       '{23'd0, 1'b1, 8'd0}});
    // masked, first pattern bright only: code ff
    dir_rows.insert(dir_rows.size(),
                    '{1'b0, {8'd0, 8'd255, 64'hFF00_0000_0000_0000, 32'h80808080}, '0});
    dir_rows.insert(dir_rows.size(), '{1'b0, {8'd0, 8'd255, {64{1'b1}}, 32'hFF00_00FF}, '0});
    // quadrant points and negative absolute phase (code 0 last quarter)
    dir_rows.insert(dir_rows.size(), '{1'b0, {8'd0, 8'd255, 64'd0, 32'h80FF_8000}, '0});
    dir_rows.insert(dir_rows.size(), '{1'b0, {8'd0, 8'd255, 64'd0, 32'h8000_80FF}, '0});
    dir_rows.insert(dir_rows.size(), '{1'b0, {8'd0, 8'd255, 64'd0, 32'h0080_FF80}, '0});
    dir_rows.insert(dir_rows.size(), '{1'b0, {8'd0, 8'd255, 64'd0, 32'hFF80_0080}, '0});
    dir_rows.insert(dir_rows.size(),
                    '{1'b0, {8'd0, 8'd255, 64'hFF00_FF00_FF00_FF00, 32'h00FF_FF00}, '0});
    dir_rows.insert(dir_rows.size(),
                    '{1'b0, {8'd10, 8'd200, 64'hAA55_AA55_AA55_AA55, 32'h0102_0304}, '0});
    dir_rows.insert(dir_rows.size(),
                    '{1'b0, {8'd0, 8'd255, 64'h8080_8080_8080_8080, 32'h00FF_00FF}, '0});

    rst <= 1'b1;
    period_shadow = gpsd_pkg::FRINGE_PERIOD_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_rows[i]) send_pixel(dir_rows[i].pix, dir_rows[i].has_exp, dir_rows[i].exp_out);
    drain_pipe();
    for (int ph = 0; ph < 6; ph++) begin
      write_period(periods[ph]);
      idle_pct = phase_idle[ph % 4];
      foreach (dir_rows[i])
        if (!dir_rows[i].has_exp) send_pixel(dir_rows[i].pix, 1'b0, '0);
      for (int n = 0; n < N_RANDOM / 6; n++) begin
        p = rand_pixel();
        send_pixel(p, 1'b0, '0);
        if (ph == 2 && n == 100) drain_pipe();
      end
      drain_pipe();
    end
    if (mismatches == 0) begin
      $display("gray_phase_shift_pixel_decode_test OK");
    end else begin
      $display("gray_phase_shift_pixel_decode_test NOT OK");
    end
    $finish;
  end
endmodule

// ----- files.f -----
hdl/gpsd_pkg.sv
hdl/gpsd_front.sv
hdl/gpsd_cordic.sv
hdl/gpsd_back.sv
hdl/gray_phase_shift_pixel_decode.sv
sim/gray_phase_shift_pixel_decode_test.sv
